// ----- rtl/bfr_pkg.sv -----
// Shared types, constants and the 5x8 font table of the bitmap font text rasteriser.
// No dependencies; every other file of the block imports this package.
package bfr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int CURSOR_BITS = COORD_BITS + 1;
  localparam int GLYPH_COUNT = 95;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 8;
  localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;
  localparam int COLOR_BITS  = 16;
  localparam int CODE_BITS   = 8;
  localparam int INDEX_BITS  = 7;

  localparam logic [CODE_BITS-1:0]  FIRST_CODE   = 8'd32;
  localparam logic [CODE_BITS-1:0]  LAST_CODE    = 8'd126;
  localparam logic [CODE_BITS-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [COLOR_BITS-1:0] TRANSPARENT  = 16'h0000;
  localparam int ADVANCE_X = 6;
  localparam int ADVANCE_Y = 9;

  // APB register map
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;
  localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd320;
  localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd240;

  // One glyph to be walked: column c of the font lies in glyph[c*8 +: 8].
  typedef struct packed {
    logic [GLYPH_BITS-1:0]  glyph;
    logic [COORD_BITS-1:0]  base_col;
    logic [CURSOR_BITS-1:0] base_row;
    logic [COLOR_BITS-1:0]  fg;
    logic [COLOR_BITS-1:0]  bg;
  } bfr_job_t;

  // Font table; only space through '9' carry bits, the other glyphs are blank.
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [INDEX_BITS-1:0] idx);
    logic [GLYPH_BITS-1:0] g;
    unique case (idx)
      7'd1:    g = 40'h00005F0000;
      7'd2:    g = 40'h0007000700;
      7'd3:    g = 40'h147F147F14;
      7'd4:    g = 40'h122A7F2A24;
      7'd5:    g = 40'h6264081323;
      7'd6:    g = 40'h5022554936;
      7'd7:    g = 40'h0000030500;
      7'd8:    g = 40'h0041221C00;
      7'd9:    g = 40'h001C224100;
      7'd10:   g = 40'h082A1C2A08;
      7'd11:   g = 40'h08083E0808;
      7'd12:   g = 40'h0000305000;
      7'd13:   g = 40'h0808080808;
      7'd14:   g = 40'h0000606000;
      7'd15:   g = 40'h0204081020;
      7'd16:   g = 40'h3E4549513E;
      7'd17:   g = 40'h00407F4200;
      7'd18:   g = 40'h4649516142;
      7'd19:   g = 40'h314B454121;
      7'd20:   g = 40'h107F121418;
      7'd21:   g = 40'h3945454527;
      7'd22:   g = 40'h3049494A3C;
      7'd23:   g = 40'h0305097101;
      7'd24:   g = 40'h3649494936;
      7'd25:   g = 40'h1E29494906;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/bfr_cfg.sv -----
// APB register file of the text rasteriser: screen width and screen height.
// Depends on bfr_pkg for the register map and reset values.
module bfr_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bfr_pkg::APB_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [bfr_pkg::APB_DATA_BITS-1:0]  cfg_pwdata,
  output logic [bfr_pkg::APB_DATA_BITS-1:0]  cfg_prdata,
  output logic                               cfg_pready,
  output logic [bfr_pkg::COORD_BITS-1:0]     screen_width,
  output logic [bfr_pkg::COORD_BITS-1:0]     screen_height
);
  import bfr_pkg::*;

  logic [COORD_BITS-1:0] width_r, width_nxt;
  logic [COORD_BITS-1:0] height_r, height_nxt;
  logic                  wr_en;
  logic                  reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_SCREEN_WIDTH:  width_nxt  = cfg_pwdata[COORD_BITS-1:0];
        REG_SCREEN_HEIGHT: height_nxt = cfg_pwdata[COORD_BITS-1:0];
        default:           width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCREEN_WIDTH_RESET;
      height_r <= SCREEN_HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SCREEN_WIDTH:  cfg_prdata = {{(APB_DATA_BITS-COORD_BITS){1'b0}}, width_r};
      REG_SCREEN_HEIGHT: cfg_prdata = {{(APB_DATA_BITS-COORD_BITS){1'b0}}, height_r};
      default:           cfg_prdata = '0;
    endcase
  end

  assign screen_width  = width_r;
  assign screen_height = height_r;

endmodule

// ----- rtl/bfr_glyph_walker.sv -----
// Glyph walker: one shared coordinate adder/compare unit steps over the 5x8 cell,
// one position a cycle when the output is free, with a one-deep hold stage to
// mark the final pixel. Depends on bfr_pkg for the job structure and constants.
module bfr_glyph_walker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  bfr_pkg::bfr_job_t               job,
  input  logic [bfr_pkg::COORD_BITS-1:0]  screen_width,
  input  logic [bfr_pkg::COORD_BITS-1:0]  screen_height,
  output logic                            busy,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bfr_pkg::COORD_BITS-1:0]  out_pixel_x,
  output logic [bfr_pkg::COORD_BITS-1:0]  out_pixel_y,
  output logic [bfr_pkg::COLOR_BITS-1:0]  out_pixel_rgb,
  output logic                            out_last_pixel
);
  import bfr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  bfr_job_t              job_r, job_nxt;
  logic [2:0]            col_r, col_nxt;
  logic [2:0]            row_r, row_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [COORD_BITS-1:0] pend_x_r, pend_x_nxt;
  logic [COORD_BITS-1:0] pend_y_r, pend_y_nxt;
  logic [COLOR_BITS-1:0] pend_color_r, pend_color_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_x_nxt;
  logic [COORD_BITS-1:0] out_y_r, out_y_nxt;
  logic [COLOR_BITS-1:0] out_color_r, out_color_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [COORD_BITS:0]   px;
  logic [COORD_BITS+1:0] py;
  logic                  px_clip;
  logic                  py_clip;
  logic                  col_last;
  logic                  row_last;
  logic                  pix_bit;
  logic [COLOR_BITS-1:0] pix_color;
  logic                  emit;
  logic                  out_free;

  // Shared coordinate unit
  assign px       = {1'b0, job_r.base_col} + {{(COORD_BITS-2){1'b0}}, col_r};
  assign py       = {1'b0, job_r.base_row} + {{(COORD_BITS-1){1'b0}}, row_r};
  assign px_clip  = px >= {1'b0, screen_width};
  assign py_clip  = py >= {2'b00, screen_height};
  assign col_last = col_r == 3'(GLYPH_COLS - 1);
  assign row_last = row_r == 3'(GLYPH_ROWS - 1);
  assign pix_bit  = job_r.glyph[{col_r, row_r}];
  assign pix_color = pix_bit ? job_r.fg : job_r.bg;
  assign emit     = !px_clip && !py_clip &&
                    ((pix_color != TRANSPARENT) || (job_r.bg != TRANSPARENT));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    pend_valid_nxt = pend_valid_r;
    pend_x_nxt     = pend_x_r;
    pend_y_nxt     = pend_y_r;
    pend_color_nxt = pend_color_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_color_nxt  = out_color_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          job_nxt   = job;
          col_nxt   = '0;
          row_nxt   = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (out_free) begin
          if (emit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_x_nxt     = pend_x_r;
              out_y_nxt     = pend_y_r;
              out_color_nxt = pend_color_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_x_nxt     = px[COORD_BITS-1:0];
            pend_y_nxt     = py[COORD_BITS-1:0];
            pend_color_nxt = pix_color;
          end
          if (px_clip || (col_last && (py_clip || row_last))) begin
            state_nxt = S_FLUSH;
          end else if (py_clip || row_last) begin
            col_nxt = col_r + 3'd1;
            row_nxt = '0;
          end else begin
            row_nxt = row_r + 3'd1;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_x_nxt     = pend_x_r;
            out_y_nxt     = pend_y_r;
            out_color_nxt = pend_color_r;
            out_last_nxt  = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    pend_x_r     <= pend_x_nxt;
    pend_y_r     <= pend_y_nxt;
    pend_color_r <= pend_color_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_color_r  <= out_color_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy            = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_rgb   = out_color_r;
  assign out_last_pixel  = out_last_r;

endmodule

// ----- rtl/bitmap_font_text_rasterizer.sv -----
// Top level of the bitmap font text rasteriser: cursor control, APB registers
// and the glyph walker. Depends on bfr_pkg, bfr_cfg and bfr_glyph_walker.
//
// Usage. Characters arrive one per transfer on the in_ channel together with
// the string origin, the foreground and background colours and a new-string
// flag. Every drawn pixel leaves as one transfer on the out_ channel, and the
// final pixel of a character carries out_last_pixel. A character that draws
// nothing (newline, stopped string, undrawable code) yields no transfer.
// Flow: a character that is ignored, a newline or an undrawable code does not
// start the walker, and the next one is accepted straight after. A drawable
// character occupies the glyph walker, which visits the 40 cells of the 5x8
// glyph one per cycle while the output register is free (fewer when an edge
// clips), then flushes the held pixel. in_ready is low while the walker is
// busy, so no new character is taken before the last one is through.
// Stalls: the walker only advances when the output register is free, so a
// stalled receiver simply stretches the walk; no pixel is lost or repeated.
// Reset (synchronous, active low) puts the cursor at 0,0, marks the string as
// stopped until a new-string character arrives, and loads the screen size
// registers with 320 by 240. Width and height are written over APB at byte
// addresses 0 and 4, and should only be changed while the block is idle.
module bitmap_font_text_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  // Character input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bfr_pkg::CODE_BITS-1:0]      in_char_code,
  input  logic [bfr_pkg::COORD_BITS-1:0]     in_origin_x,
  input  logic [bfr_pkg::COORD_BITS-1:0]     in_origin_y,
  input  logic [bfr_pkg::COLOR_BITS-1:0]     in_fg_color,
  input  logic [bfr_pkg::COLOR_BITS-1:0]     in_bg_color,
  input  logic                               in_new_string,
  // Pixel output channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bfr_pkg::COORD_BITS-1:0]     out_pixel_x,
  output logic [bfr_pkg::COORD_BITS-1:0]     out_pixel_y,
  output logic [bfr_pkg::COLOR_BITS-1:0]     out_pixel_rgb,
  output logic                               out_last_pixel,
  // APB configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bfr_pkg::APB_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [bfr_pkg::APB_DATA_BITS-1:0]  cfg_pwdata,
  output logic [bfr_pkg::APB_DATA_BITS-1:0]  cfg_prdata,
  output logic                               cfg_pready
);
  import bfr_pkg::*;

  logic [COORD_BITS-1:0]  screen_width;
  logic [COORD_BITS-1:0]  screen_height;
  logic                   walker_busy;
  logic                   accept;

  logic [CURSOR_BITS-1:0] cursor_col_r, cursor_col_nxt;
  logic [CURSOR_BITS-1:0] cursor_row_r, cursor_row_nxt;
  logic                   stopped_r, stopped_nxt;

  logic [CURSOR_BITS-1:0] eff_col;
  logic [CURSOR_BITS-1:0] eff_row;
  logic                   eff_stopped;
  logic [CURSOR_BITS-1:0] newline_row;
  logic [CODE_BITS-1:0]   code_offset;
  logic [INDEX_BITS-1:0]  glyph_idx;
  logic                   drawable;
  logic                   start;
  bfr_job_t               job;

  bfr_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  assign in_ready = !walker_busy;
  assign accept   = in_valid && in_ready;

  // A new string loads the cursor from the origin and restarts the string
  // before the character itself is looked at.
  assign eff_col     = in_new_string ? {1'b0, in_origin_x} : cursor_col_r;
  assign eff_row     = in_new_string ? {1'b0, in_origin_y} : cursor_row_r;
  assign eff_stopped = in_new_string ? 1'b0 : stopped_r;
  assign newline_row = eff_row + CURSOR_BITS'(ADVANCE_Y);

  assign code_offset = in_char_code - FIRST_CODE;
  assign glyph_idx   = code_offset[INDEX_BITS-1:0];
  assign drawable    = (in_char_code >= FIRST_CODE) && (in_char_code <= LAST_CODE) &&
                       (glyph_idx < INDEX_BITS'(GLYPH_COUNT));

  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    stopped_nxt    = stopped_r;
    start          = 1'b0;
    if (accept) begin
      cursor_col_nxt = eff_col;
      cursor_row_nxt = eff_row;
      stopped_nxt    = eff_stopped;
      priority if (eff_stopped) begin
        // The string has ended: the character is dropped.
        stopped_nxt = 1'b1;
      end else if (eff_col >= {1'b0, screen_width}) begin
        // Cursor has run off the right edge; end the string.
        stopped_nxt = 1'b1;
      end else if (in_char_code == NEWLINE_CODE) begin
        cursor_col_nxt = {1'b0, in_origin_x};
        cursor_row_nxt = newline_row;
        stopped_nxt    = newline_row >= {1'b0, screen_height};
      end else begin
        // Every other code advances the cursor; only printable ones are drawn.
        cursor_col_nxt = eff_col + CURSOR_BITS'(ADVANCE_X);
        start          = drawable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      stopped_r    <= 1'b1;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  // The glyph is fetched from the font table here, so the walker only
  // selects one bit of the latched cell per cycle.
  always_comb begin
    job.glyph    = glyph_bits(glyph_idx);
    job.base_col = eff_col[COORD_BITS-1:0];
    job.base_row = eff_row;
    job.fg       = in_fg_color;
    job.bg       = in_bg_color;
  end

  bfr_glyph_walker u_walker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .job             (job),
    .screen_width    (screen_width),
    .screen_height   (screen_height),
    .busy            (walker_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_rgb   (out_pixel_rgb),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

// ----- test/bfr_tb_pkg.sv -----
`timescale 1ns / 100ps
// Pixel scoreboard for the bitmap font text rasteriser: a cursor model, a copy of the
// 5x8 font in column order and the queue of pixels still due. Depends on bfr_pkg.
package bfr_tb_pkg;
  import bfr_pkg::*;

  // Glyphs from space through '9' carry bits; every later glyph is blank.
  localparam int DEFINED_GLYPHS = 26;

  // One glyph per 40-bit word, written left column first, space at the top.
  localparam logic [DEFINED_GLYPHS*GLYPH_BITS-1:0] FONT_TABLE = {
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E
  };

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_rec_t;

  class pixel_scoreboard;
    logic [COORD_BITS-1:0]  screen_w;
    logic [COORD_BITS-1:0]  screen_h;
    logic [CURSOR_BITS-1:0] cur_col;
    logic [CURSOR_BITS-1:0] cur_row;
    bit                     stopped;
    pixel_rec_t             pixels_due[$];
    int                     mismatches;

    function new();
      screen_w   = SCREEN_WIDTH_RESET;
      screen_h   = SCREEN_HEIGHT_RESET;
      cur_col    = '0;
      cur_row    = '0;
      stopped    = 1'b1;
      mismatches = 0;
    endfunction

    function void set_screen(input logic reg_idx, input logic [COORD_BITS-1:0] value);
      if (reg_idx == REG_SCREEN_WIDTH) begin
        screen_w = value;
      end else begin
        screen_h = value;
      end
    endfunction

    // Updates the cursor for one accepted character and queues the pixels it draws.
    // Returns 0 when the character was ignored because the string had stopped or the cursor was past the right edge.
    function bit rasterise_char(input logic [CODE_BITS-1:0] code,
                                input logic [COORD_BITS-1:0] ox, oy,
                                input logic [COLOR_BITS-1:0] fg, bg,
                                input logic ns);
      int                    idx;
      int                    drawn;
      int                    px;
      int                    py;
      logic [7:0]            column;
      logic [COLOR_BITS-1:0] color;
      pixel_rec_t            p;
      if (ns) begin
        cur_col = {1'b0, ox};
        cur_row = {1'b0, oy};
        stopped = 1'b0;
      end
      if (stopped) return 1'b0;
      if (int'(cur_col) >= int'(screen_w)) begin
        stopped = 1'b1;
        return 1'b0;
      end
      if (code == NEWLINE_CODE) begin
        cur_col = {1'b0, ox};
        cur_row = CURSOR_BITS'(int'(cur_row) + ADVANCE_Y);
        if (int'(cur_row) >= int'(screen_h)) stopped = 1'b1;
        return 1'b1;
      end
      if (code >= FIRST_CODE && code <= LAST_CODE) begin
        idx   = int'(code) - int'(FIRST_CODE);
        drawn = 0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
          px = int'(cur_col) + c;
          if (px >= int'(screen_w)) break;
          column = (idx < DEFINED_GLYPHS) ?
              FONT_TABLE[(DEFINED_GLYPHS - 1 - idx) * GLYPH_BITS + (GLYPH_COLS - 1 - c) * 8 +: 8]
              : 8'h00;
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            py = int'(cur_row) + r;
            if (py >= int'(screen_h)) break;
            color = column[r] ? fg : bg;
            if (color != bg || bg != TRANSPARENT) begin
              p.x     = px[COORD_BITS-1:0];
              p.y     = py[COORD_BITS-1:0];
              p.color = color;
              p.last  = 1'b0;
              pixels_due.push_back(p);
              drawn++;
            end
          end
        end
        if (drawn > 0) begin
          p      = pixels_due.pop_back();
          p.last = 1'b1;
          pixels_due.push_back(p);
        end
      end
      cur_col = CURSOR_BITS'(int'(cur_col) + ADVANCE_X);
      return 1'b1;
    endfunction

    function void compare_field(input string what, input logic [31:0] want, got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void check_pixel(input logic [COORD_BITS-1:0] x, y,
                              input logic [COLOR_BITS-1:0] color, input logic last);
      pixel_rec_t want;
      if (pixels_due.size() == 0) begin
        mismatches++;
        $display("%0t: expected no pixel, got x=%0d y=%0d colour=%h last=%b",
                 $time, x, y, color, last);
        return;
      end
      want = pixels_due.pop_front();
      compare_field("pixel_x", 32'(want.x), 32'(x));
      compare_field("pixel_y", 32'(want.y), 32'(y));
      compare_field("pixel_rgb", 32'(want.color), 32'(color));
      compare_field("last_pixel", 32'(want.last), 32'(last));
    endfunction
  endclass

endpackage

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_font_text_rasterizer: characters, APB screen size
// writes and a stalling pixel receiver. Depends on bfr_pkg and bfr_tb_pkg.
module testbench;
  import bfr_pkg::*;
  import bfr_tb_pkg::*;

  // A blank glyph with a transparent background draws nothing but still keeps the
  // walker busy, so the quiet period before a register write is long enough for
  // the walker to finish such a glyph.
  localparam int SETTLE_CYCLES      = 64;
  localparam int CYCLE_LIMIT        = 1_000_000;
  localparam int ITEMS_PER_PHASE    = 40;
  localparam int HOLD_OFF_CYCLES    = 300;
  localparam int PHASES             = 7;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // Screen sizes visited after the directed part, the extremes among them.
  localparam logic [COORD_BITS-1:0] PHASE_W [PHASES] =
      '{12'd4095, 12'd1, 12'd64, 12'd17, 12'd320, 12'd4095, 12'd7};
  localparam logic [COORD_BITS-1:0] PHASE_H [PHASES] =
      '{12'd4095, 12'd1, 12'd40, 12'd12, 12'd240, 12'd9, 12'd4095};

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_ready;
  logic [CODE_BITS-1:0]     in_char_code    = '0;
  logic [COORD_BITS-1:0]    in_origin_x     = '0;
  logic [COORD_BITS-1:0]    in_origin_y     = '0;
  logic [COLOR_BITS-1:0]    in_fg_color     = '0;
  logic [COLOR_BITS-1:0]    in_bg_color     = '0;
  logic                     in_new_string   = 1'b0;
  logic                     out_valid;
  logic                     out_ready       = 1'b0;
  logic [COORD_BITS-1:0]    out_pixel_x;
  logic [COORD_BITS-1:0]    out_pixel_y;
  logic [COLOR_BITS-1:0]    out_pixel_rgb;
  logic                     out_last_pixel;
  logic                     cfg_psel        = 1'b0;
  logic                     cfg_penable     = 1'b0;
  logic                     cfg_pwrite      = 1'b0;
  logic [APB_ADDR_BITS-1:0] cfg_paddr       = '0;
  logic [APB_DATA_BITS-1:0] cfg_pwdata      = '0;
  logic [APB_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  pixel_scoreboard sb;
  int       cfg_errors    = 0;
  int       offered_chars = 0;
  int       burst_left    = 0;
  int       cycle_count   = 0;
  int       rx_cycles     = 0;
  int       hold_left     = 0;
  rx_mode_t rx_mode       = RX_ALWAYS;

  bitmap_font_text_rasterizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_fg_color     (in_fg_color),
    .in_bg_color     (in_bg_color),
    .in_new_string   (in_new_string),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_rgb   (out_pixel_rgb),
    .out_last_pixel  (out_last_pixel),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always #5 clk = ~clk;

  // Any run that outlives this many cycles has hung somewhere.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Pixel receiver. It switches between a handful of stall patterns, and now and
  // then holds off for a long stretch so that the walker stalls, in_ready stays
  // low and the sender is left waiting with a character.
  always @(negedge clk) begin
    rx_cycles++;
    if (rx_cycles % 4000 == 1500) hold_left = HOLD_OFF_CYCLES;
    if (rx_cycles % 150 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready = 1'b1;
        RX_COIN:   out_ready = 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
        default:   out_ready = ((rx_cycles / 4) % 2 == 0);
      endcase
    end
  end

  // Every pixel transfer is checked against the oldest pixel still due.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      sb.check_pixel(out_pixel_x, out_pixel_y, out_pixel_rgb, out_last_pixel);
    end
  end

  // Offers one character and waits for its transfer. The sender works in bursts:
  // once a burst is used up it may drop valid before the next one.
  task automatic offer_char(input logic [CODE_BITS-1:0] code,
                            input logic [COORD_BITS-1:0] ox, oy,
                            input logic [COLOR_BITS-1:0] fg, bg,
                            input logic ns);
    int gap;
    @(negedge clk);
    in_valid      = 1'b1;
    in_char_code  = code;
    in_origin_x   = ox;
    in_origin_y   = oy;
    in_fg_color   = fg;
    in_bg_color   = bg;
    in_new_string = ns;
    do @(posedge clk); while (!in_ready);
    offered_chars++;
    void'(sb.rasterise_char(code, ox, oy, fg, bg, ns));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Long bursts give stretches with no idling at all.
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(20, 60);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk) in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Lets the block run dry: every pixel due has arrived and the walker has
  // had time to finish a glyph that draws nothing.
  task automatic settle();
    @(negedge clk) in_valid = 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one screen size register, then reads it back in the following transfer.
  task automatic apb_write_check(input logic reg_idx, input logic [COORD_BITS-1:0] value);
    logic [APB_DATA_BITS-1:0] rd;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {reg_idx, 2'b00};
    cfg_pwdata  = APB_DATA_BITS'(value);
    @(negedge clk) cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_screen(reg_idx, value);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk) cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (rd[COORD_BITS-1:0] !== value) begin
      cfg_errors++;
      $display("%0t: register %0d read back, expected %0h, got %0h", $time, reg_idx, value,
               rd[COORD_BITS-1:0]);
    end
  endtask

  // Mostly near the start of the screen so that strings run for a while, some near
  // the far edge so that clipping and stopping happen, a few anywhere at all.
  function automatic logic [COORD_BITS-1:0] pick_origin(input int span);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return COORD_BITS'($urandom_range(0, (span - 1) / 4));
    if (pick < 8) return COORD_BITS'($urandom_range(span > 12 ? span - 12 : 0, span - 1));
    if (pick == 8) return COORD_BITS'($urandom_range(0, span - 1));
    return COORD_BITS'($urandom);
  endfunction

  // One string: a new-string character followed by a run of characters with random
  // content. About one string in eight is broken: it may continue the previous
  // cursor instead of starting afresh, from an origin anywhere at all.
  task automatic random_string(input int span_w, input int span_h);
    logic [COORD_BITS-1:0] ox, oy;
    logic [COLOR_BITS-1:0] fg, bg;
    logic [CODE_BITS-1:0]  code;
    logic                  ns;
    int                    len;
    int                    pick;
    bit                    broken;
    broken = ($urandom_range(0, 7) == 0);
    ox     = broken ? COORD_BITS'($urandom) : pick_origin(span_w);
    oy     = broken ? COORD_BITS'($urandom) : pick_origin(span_h);
    len    = $urandom_range(1, 14);
    fg     = '0;
    bg     = '0;
    for (int i = 0; i < len; i++) begin
      if (i == 0 || $urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 19);
        fg   = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : COLOR_BITS'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 8) bg = TRANSPARENT;
        else if (pick < 10) bg = fg;
        else if (pick == 10) bg = 16'hFFFF;
        else bg = COLOR_BITS'($urandom);
      end
      // A changed origin only matters to a later newline or new-string character of this string.
      if (i > 0 && $urandom_range(0, 15) == 0) ox = pick_origin(span_w);
      pick = $urandom_range(0, 99);
      if (pick < 55) code = CODE_BITS'($urandom_range(32, 57));
      else if (pick < 65) code = CODE_BITS'($urandom_range(58, 126));
      else if (pick < 78) code = NEWLINE_CODE;
      else if (pick < 86) code = CODE_BITS'($urandom_range(0, 31));
      else if (pick < 94) code = CODE_BITS'($urandom_range(127, 255));
      else code = CODE_BITS'($urandom);
      if (i == 0) ns = broken ? 1'($urandom) : 1'b1;
      else ns = ($urandom_range(0, 24) == 0);
      offer_char(code, ox, oy, fg, bg, ns);
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed part, on the reset screen of 320 by 240.
    // The string is stopped out of reset, so a plain character is ignored.
    offer_char(8'h41, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    // '0' at the top left corner, transparent background.
    offer_char(8'h30, 12'd0, 12'd0, 16'hFFFF, TRANSPARENT, 1'b1);
    // '8' on a solid background: all 40 cells are drawn.
    offer_char(8'h38, 12'd0, 12'd0, 16'h1234, 16'hFFFF, 1'b0);
    // A zero foreground on a transparent background draws nothing.
    offer_char(8'h21, 12'd0, 12'd0, 16'h0000, TRANSPARENT, 1'b0);
    // A space on a non-zero background paints the whole cell.
    offer_char(8'h20, 12'd0, 12'd0, 16'hFFFF, 16'h0001, 1'b0);
    // Undrawable codes at both ends of the byte and either side of the printable range.
    offer_char(8'h00, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    offer_char(8'hFF, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    offer_char(8'h1F, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    offer_char(8'h7F, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    // '~' is the last printable code and its glyph is blank.
    offer_char(8'h7E, 12'd0, 12'd0, 16'hFFFF, 16'h8000, 1'b0);
    offer_char(NEWLINE_CODE, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    // Foreground equal to background: every cell still goes out.
    offer_char(8'h23, 12'd0, 12'd0, 16'h5555, 16'h5555, 1'b0);
    // Near the bottom right corner the glyph is clipped both ways, the next character
    // meets the right edge and stops the string, the one after is ignored.
    offer_char(8'h35, 12'd316, 12'd236, 16'hF800, 16'h07E0, 1'b1);
    offer_char(8'h32, 12'd316, 12'd236, 16'hF800, 16'h07E0, 1'b0);
    offer_char(8'h33, 12'd316, 12'd236, 16'hF800, 16'h07E0, 1'b0);
    // An origin at the largest coordinates is past the right edge at once.
    offer_char(8'h39, 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF, 1'b1);
    // Newlines walk down to the last row and then past the bottom edge.
    offer_char(NEWLINE_CODE, 12'd0, 12'd230, 16'hFFFF, TRANSPARENT, 1'b1);
    offer_char(8'h37, 12'd0, 12'd230, 16'hFFFF, TRANSPARENT, 1'b0);
    offer_char(NEWLINE_CODE, 12'd0, 12'd230, 16'hFFFF, TRANSPARENT, 1'b0);
    offer_char(8'h31, 12'd0, 12'd230, 16'hFFFF, TRANSPARENT, 1'b0);
    // A zero foreground over a non-zero background is still drawn.
    offer_char(8'h34, 12'd160, 12'd120, 16'h0000, 16'hFFFF, 1'b1);
    offer_char(8'h2F, 12'd160, 12'd120, 16'hAAAA, TRANSPARENT, 1'b0);
    settle();

    // Random strings under a series of screen sizes, about forty characters under
    // each size.
    for (int ph = 0; ph < PHASES; ph++) begin
      apb_write_check(REG_SCREEN_WIDTH, PHASE_W[ph]);
      apb_write_check(REG_SCREEN_HEIGHT, PHASE_H[ph]);
      offered_chars = 0;
      while (offered_chars < ITEMS_PER_PHASE) begin
        random_string(int'(PHASE_W[ph]), int'(PHASE_H[ph]));
      end
      settle();
    end

    if (sb.mismatches == 0 && cfg_errors == 0 && sb.pixels_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bfr_pkg.sv
rtl/bfr_cfg.sv
rtl/bfr_glyph_walker.sv
rtl/bitmap_font_text_rasterizer.sv
test/bfr_tb_pkg.sv
test/testbench.sv
